FILE: src/ufp_pkg.sv
// Shared constants for the UART ring-buffer pair with RTS flow control.
// Holds command codes, register indexes and fixed byte values; no dependencies.
package ufp_pkg;

    localparam int CMD_W  = 3;
    localparam int BYTE_W = 8;
    localparam int REG_W  = 8;

    // Command codes carried by the command field of an input item.
    localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOST_RD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HOST_WR  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd5;

    // Configuration register indexes.
    localparam logic REG_HIGH_WATER = 1'b0;
    localparam logic REG_LOW_WATER  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [REG_W-1:0] HIGH_WATER_RST = 8'd192;
    localparam logic [REG_W-1:0] LOW_WATER_RST  = 8'd64;

    // Byte left alone in the receive ring by a cancel.
    localparam logic [BYTE_W-1:0] CANCEL_BYTE = 8'h18;

endpackage

FILE: src/ufp_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for both rings of the UART buffer block; no package dependencies.
module ufp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/uart_fifo_pair_rts_flow.sv
// Top level of the UART buffer block: receive ring, transmit ring, RTS control.
// Depends on ufp_pkg for command codes and constants, and on ufp_ram for storage.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------------
//  input     in_valid / in_stall  command, data_byte, realtime_taken, shifter_idle
//  output    out_valid/out_stall  read_data, read_valid, send_data, send_valid,
//                                 write_refused, rx_count, rx_free, tx_count,
//                                 overflow_flag, rts_level
//  config    cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// One item is accepted per cycle while in_stall is low. The ring memory read launched
// at acceptance returns its data with the item in the middle stage, and the data is
// loaded into the output register when the middle stage advances.
// The ring memories need no clearing after reset: pointers and counts start at zero.
// A stalled output holds its item; the middle stage then holds too and in_stall
// rises, so at most two items are in flight.
module uart_fifo_pair_rts_flow #(
    parameter int RX_DEPTH = 256,
    parameter int TX_DEPTH = 128
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ufp_pkg::CMD_W-1:0]     command,
    input  logic [ufp_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          realtime_taken,
    input  logic                          shifter_idle,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ufp_pkg::BYTE_W-1:0]    read_data,
    output logic                          read_valid,
    output logic [ufp_pkg::BYTE_W-1:0]    send_data,
    output logic                          send_valid,
    output logic                          write_refused,
    output logic [$clog2(RX_DEPTH)-1:0]   rx_count,
    output logic [$clog2(RX_DEPTH):0]     rx_free,
    output logic [$clog2(TX_DEPTH)-1:0]   tx_count,
    output logic                          overflow_flag,
    output logic                          rts_level,

    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ufp_pkg::REG_W-1:0]     cfg_data
);

    import ufp_pkg::*;

    // Pointer and count widths. A ring keeps one slot empty, so its count never
    // exceeds DEPTH-1 and fits in the pointer width.
    localparam int RX_AW   = $clog2(RX_DEPTH);
    localparam int TX_AW   = $clog2(TX_DEPTH);
    localparam int RX_CMPW = (RX_AW > REG_W) ? RX_AW : REG_W;

    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
    localparam logic [RX_AW:0]   RX_SIZE = (RX_AW + 1)'(RX_DEPTH);

    // Everything the middle stage carries besides the memory read data.
    typedef struct packed {
        logic              rd_from_ram;
        logic              sd_from_ram;
        logic              send_direct;
        logic [BYTE_W-1:0] direct_byte;
        logic              refused;
        logic [RX_AW-1:0]  rx_cnt;
        logic [TX_AW-1:0]  tx_cnt;
        logic              ovf;
        logic              rts;
    } stage_t;

    // Configuration registers.
    logic [REG_W-1:0] high_water_reg;
    logic [REG_W-1:0] low_water_reg;

    // Ring state.
    logic [RX_AW-1:0] rx_wp_reg, rx_wp_next;
    logic [RX_AW-1:0] rx_rp_reg, rx_rp_next;
    logic [RX_AW-1:0] rx_cnt_reg, rx_cnt_next;
    logic [TX_AW-1:0] tx_wp_reg, tx_wp_next;
    logic [TX_AW-1:0] tx_rp_reg, tx_rp_next;
    logic [TX_AW-1:0] tx_cnt_reg, tx_cnt_next;
    logic             ovf_reg, ovf_next;
    logic             rts_reg, rts_next;

    // Middle stage and output register.
    logic             mid_valid_reg, mid_valid_next;
    stage_t           mid_reg, mid_next;
    logic             out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] read_data_reg;
    logic              read_valid_reg;
    logic [BYTE_W-1:0] send_data_reg;
    logic              send_valid_reg;
    logic              refused_reg;
    logic [RX_AW-1:0]  rx_count_reg;
    logic [RX_AW:0]    rx_free_reg;
    logic [TX_AW-1:0]  tx_count_reg;
    logic              ovf_out_reg;
    logic              rts_out_reg;

    // Memory control.
    logic              rx_we, rx_re, tx_we, tx_re;
    logic [RX_AW-1:0]  rx_waddr;
    logic [BYTE_W-1:0] rx_wdata;
    logic [BYTE_W-1:0] rx_rdata, tx_rdata;

    logic accept;
    logic advance;
    logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
    logic [RX_AW-1:0] rx_level;

    // The middle stage moves on whenever the output register is free or being
    // emptied; a new item can enter the middle stage in the same cycle.
    assign advance  = mid_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = mid_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Wrap-around increments that also work for depths that are not powers of two.
    assign rx_wp_inc = (rx_wp_reg == RX_LAST) ? '0 : rx_wp_reg + 1'b1;
    assign rx_rp_inc = (rx_rp_reg == RX_LAST) ? '0 : rx_rp_reg + 1'b1;
    assign tx_wp_inc = (tx_wp_reg == TX_LAST) ? '0 : tx_wp_reg + 1'b1;
    assign tx_rp_inc = (tx_rp_reg == TX_LAST) ? '0 : tx_rp_reg + 1'b1;

    // Command decode. All pointer updates and memory writes happen at acceptance;
    // a pop only launches the memory read, whose data joins the item in the middle stage.
    always_comb
    begin
        rx_wp_next  = rx_wp_reg;
        rx_rp_next  = rx_rp_reg;
        rx_cnt_next = rx_cnt_reg;
        tx_wp_next  = tx_wp_reg;
        tx_rp_next  = tx_rp_reg;
        tx_cnt_next = tx_cnt_reg;
        ovf_next    = ovf_reg;
        rts_next    = rts_reg;
        rx_we       = 1'b0;
        rx_re       = 1'b0;
        tx_we       = 1'b0;
        tx_re       = 1'b0;
        rx_waddr    = rx_wp_reg;
        rx_wdata    = data_byte;
        rx_level    = rx_cnt_reg;
        mid_next    = '0;

        if (accept)
        begin
            unique case (command)
                CMD_RX_BYTE:
                begin
                    if (rx_cnt_reg == RX_LAST)
                    begin
                        // Ring full: drop the byte and set the overflow flag.
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        // A byte the realtime filter took is not stored, but the
                        // high-water check still runs on the current level.
                        if (!realtime_taken)
                        begin
                            rx_we       = 1'b1;
                            rx_wp_next  = rx_wp_inc;
                            rx_cnt_next = rx_cnt_reg + 1'b1;
                            rx_level    = rx_cnt_reg + 1'b1;
                        end
                        if (!rts_reg && (RX_CMPW'(rx_level) >= RX_CMPW'(high_water_reg)))
                        begin
                            rts_next = 1'b1;
                        end
                    end
                end
                CMD_HOST_RD:
                begin
                    if (rx_cnt_reg != '0)
                    begin
                        rx_re                = 1'b1;
                        mid_next.rd_from_ram = 1'b1;
                        rx_rp_next           = rx_rp_inc;
                        rx_cnt_next          = rx_cnt_reg - 1'b1;
                        if (rts_reg && (RX_CMPW'(rx_cnt_next) < RX_CMPW'(low_water_reg)))
                        begin
                            rts_next = 1'b0;
                        end
                    end
                end
                CMD_HOST_WR:
                begin
                    if (shifter_idle && (tx_cnt_reg == '0))
                    begin
                        // Nothing queued and the shifter is free: bypass the ring.
                        mid_next.send_direct = 1'b1;
                        mid_next.direct_byte = data_byte;
                    end
                    else if (tx_cnt_reg == TX_LAST)
                    begin
                        mid_next.refused = 1'b1;
                    end
                    else
                    begin
                        tx_we       = 1'b1;
                        tx_wp_next  = tx_wp_inc;
                        tx_cnt_next = tx_cnt_reg + 1'b1;
                    end
                end
                CMD_TX_READY:
                begin
                    if (tx_cnt_reg != '0)
                    begin
                        tx_re                = 1'b1;
                        mid_next.sd_from_ram = 1'b1;
                        tx_rp_next           = tx_rp_inc;
                        tx_cnt_next          = tx_cnt_reg - 1'b1;
                    end
                end
                CMD_FLUSH:
                begin
                    // The overflow flag survives a flush; only reset clears it.
                    rx_wp_next  = '0;
                    rx_rp_next  = '0;
                    rx_cnt_next = '0;
                    rts_next    = 1'b0;
                end
                CMD_CANCEL:
                begin
                    // The ring is left holding the single cancel byte.
                    rx_we       = 1'b1;
                    rx_wdata    = CANCEL_BYTE;
                    rx_rp_next  = rx_wp_reg;
                    rx_wp_next  = rx_wp_inc;
                    rx_cnt_next = RX_AW'(1);
                    rts_next    = 1'b0;
                end
                default:
                begin
                    // Unused codes change nothing and report status only.
                end
            endcase

            mid_next.rx_cnt = rx_cnt_next;
            mid_next.tx_cnt = tx_cnt_next;
            mid_next.ovf    = ovf_next;
            mid_next.rts    = rts_next;
        end
    end

    assign mid_valid_next = accept | (mid_valid_reg & ~advance);
    assign out_valid_next = advance | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_water_reg <= HIGH_WATER_RST;
            low_water_reg  <= LOW_WATER_RST;
            rx_wp_reg      <= '0;
            rx_rp_reg      <= '0;
            rx_cnt_reg     <= '0;
            tx_wp_reg      <= '0;
            tx_rp_reg      <= '0;
            tx_cnt_reg     <= '0;
            ovf_reg        <= 1'b0;
            rts_reg        <= 1'b0;
            mid_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_HIGH_WATER: high_water_reg <= cfg_data;
                    REG_LOW_WATER:  low_water_reg  <= cfg_data;
                    default:        high_water_reg <= high_water_reg;
                endcase
            end
            rx_wp_reg     <= rx_wp_next;
            rx_rp_reg     <= rx_rp_next;
            rx_cnt_reg    <= rx_cnt_next;
            tx_wp_reg     <= tx_wp_next;
            tx_rp_reg     <= tx_rp_next;
            tx_cnt_reg    <= tx_cnt_next;
            ovf_reg       <= ovf_next;
            rts_reg       <= rts_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_reg <= mid_next;
        end
        if (advance)
        begin
            read_data_reg  <= mid_reg.rd_from_ram ? rx_rdata : '0;
            read_valid_reg <= mid_reg.rd_from_ram;
            send_data_reg  <= mid_reg.sd_from_ram ? tx_rdata : mid_reg.direct_byte;
            send_valid_reg <= mid_reg.sd_from_ram | mid_reg.send_direct;
            refused_reg    <= mid_reg.refused;
            rx_count_reg   <= mid_reg.rx_cnt;
            rx_free_reg    <= RX_SIZE - {1'b0, mid_reg.rx_cnt};
            tx_count_reg   <= mid_reg.tx_cnt;
            ovf_out_reg    <= mid_reg.ovf;
            rts_out_reg    <= mid_reg.rts;
        end
    end

    // A write and a read of the same command never touch one ring in the same
    // cycle, and a slot read after being written was written at an earlier edge.
    ufp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (rx_wdata),
        .re    (rx_re),
        .raddr (rx_rp_reg),
        .rdata (rx_rdata)
    );

    ufp_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_wp_reg),
        .wdata (data_byte),
        .re    (tx_re),
        .raddr (tx_rp_reg),
        .rdata (tx_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign read_valid    = read_valid_reg;
    assign send_data     = send_data_reg;
    assign send_valid    = send_valid_reg;
    assign write_refused = refused_reg;
    assign rx_count      = rx_count_reg;
    assign rx_free       = rx_free_reg;
    assign tx_count      = tx_count_reg;
    assign overflow_flag = ovf_out_reg;
    assign rts_level     = rts_out_reg;

endmodule
